/* rtl/core/css_chirp_sample_generator_top_macros.svh */
// Assertion shorthands for the chirp generator; clk and rst_n come from the
// module that uses them.
`ifndef CSS_CHIRP_SAMPLE_GENERATOR_TOP_MACROS_SVH
`define CSS_CHIRP_SAMPLE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, silent while in reset.
`define CSSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay before the consequent.
`define CSSG_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## (dly) (cons)) \
    else $error(msg);

`endif

/* rtl/core/cssg_pkg.sv */
package cssg_pkg;

  // Field and register widths
  localparam int SF_W       = 4;
  localparam int OSL_W      = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int SAMPLE_W   = 15;
  localparam int SYMBOL_W   = 12;
  localparam int Q15_W      = 16;

  localparam int SF_MIN     = 5;
  localparam int OSL_MAX    = 3;
  localparam logic [SF_W-1:0]  SF_RESET  = 4'd7;
  localparam logic [OSL_W-1:0] OSL_RESET = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPREADING_FACTOR = 1'b0,
    CFG_OVERSAMPLE_LOG2  = 1'b1
  } cssg_cfg_idx_t;

  // Rotation datapath
  localparam int ROT_W        = 32;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 32'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [ROT_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
    32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
    32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
    32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41,
    32'sd20,        32'sd10,        32'sd5,         32'sd3,        32'sd1
  };

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } cssg_quad_t;

  typedef struct packed {
    cssg_quad_t               quad;
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [ROT_W-1:0]  z;
  } cssg_rot_t;

  // Q15 output
  localparam int Q15_FRAC = 15;
  localparam int Q15_HALF = 16384;
  localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sh7fff;
  localparam logic signed [Q15_W-1:0] Q15_MIN = 16'sh8000;

  // Pipeline depth: input, product and angle registers, then the rotation
  // stages, then the output register.
  localparam int PHASE_DEPTH = 3;
  localparam int LATENCY     = PHASE_DEPTH + CORDIC_STEPS + 1;

endpackage

/* rtl/core/cssg_phase.sv */
module cssg_phase import cssg_pkg::*; #(
  parameter int MAX_SF      = 12,
  parameter int MAX_OS_LOG2 = 3,
  parameter int PHASE_BITS  = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_i,
  input  logic [SAMPLE_W-1:0] sample_index_i,
  input  logic [SYMBOL_W-1:0] symbol_value_i,
  input  logic [SF_W-1:0]     sf_i,
  input  logic [OSL_W-1:0]    osl_i,
  output logic                rot_valid_o,
  output cssg_rot_t           rot_o
);

  localparam int OSL_CAP = (MAX_OS_LOG2 < OSL_MAX) ? MAX_OS_LOG2 : OSL_MAX;
  localparam int MOD_W   = 1 + MAX_SF + 2 * OSL_CAP;
  localparam int LOG2M_W = $clog2(MOD_W + 1);
  localparam int FOLD_W  = MAX_SF + OSL_CAP + 1;
  localparam int CMP_W   = (SAMPLE_W > FOLD_W) ? SAMPLE_W : FOLD_W;

  // Input register
  logic                a_valid_r;
  logic [SAMPLE_W-1:0] a_index_r;
  logic [SYMBOL_W-1:0] a_symbol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= req_i;
    end
  end

  always_ff @(posedge clk) begin
    a_index_r  <= sample_index_i;
    a_symbol_r <= symbol_value_i;
  end

  // Clamp configuration, wrap index and symbol, form the two products
  logic [SF_W-1:0]     sf_c;
  logic [OSL_W-1:0]    osl_c;
  logic [SF_W:0]       nsh_c;
  logic [SAMPLE_W-1:0] n_c;
  logic [SYMBOL_W-1:0] id_c;
  logic [FOLD_W-1:0]   nb_f;
  logic [FOLD_W-1:0]   nfold_c;
  logic                fold_c;
  logic [MOD_W-1:0]    n_m;
  logic [MOD_W-1:0]    a_m;
  logic [MOD_W-1:0]    nb_m;
  logic [MOD_W-1:0]    coef_m;
  logic [MOD_W-1:0]    n2_nxt;
  logic [MOD_W-1:0]    ac_nxt;
  logic [LOG2M_W-1:0]  log2m_nxt;

  always_comb begin
    sf_c = sf_i;
    if (int'(sf_i) < SF_MIN) begin
      sf_c = SF_W'(SF_MIN);
    end else if (int'(sf_i) > MAX_SF) begin
      sf_c = SF_W'(MAX_SF);
    end
    osl_c = osl_i;
    if (int'(osl_i) > OSL_CAP) begin
      osl_c = OSL_W'(OSL_CAP);
    end

    nsh_c   = {1'b0, sf_c} + (SF_W+1)'(osl_c);
    n_c     = a_index_r & ~({SAMPLE_W{1'b1}} << nsh_c);
    id_c    = a_symbol_r & ~({SYMBOL_W{1'b1}} << sf_c);
    nb_f    = FOLD_W'(1) << sf_c;
    nfold_c = (nb_f - FOLD_W'(id_c)) << osl_c;
    fold_c  = CMP_W'(n_c) >= CMP_W'(nfold_c);

    // Everything below is modulo 2^MOD_W; the true modulus divides it.
    n_m    = MOD_W'(n_c);
    a_m    = n_m << osl_c;
    nb_m   = MOD_W'(1) << sf_c;
    coef_m = (MOD_W'(id_c) << 1) - nb_m - (fold_c ? (nb_m << 1) : MOD_W'(0));

    n2_nxt    = n_m * n_m;
    ac_nxt    = a_m * coef_m;
    log2m_nxt = LOG2M_W'(int'(sf_c) + 2 * int'(osl_c) + 1);
  end

  // Product register
  logic               b_valid_r;
  logic [MOD_W-1:0]   b_n2_r;
  logic [MOD_W-1:0]   b_ac_r;
  logic [LOG2M_W-1:0] b_log2m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_n2_r    <= n2_nxt;
    b_ac_r    <= ac_nxt;
    b_log2m_r <= log2m_nxt;
  end

  // Reduce to the true modulus and rescale to PHASE_BITS
  logic [MOD_W-1:0]            p_sum;
  logic [MOD_W-1:0]            p_c;
  logic [MOD_W+PHASE_BITS-1:0] pp_c;
  logic [PHASE_BITS-1:0]       idx_c;
  cssg_rot_t                   rot_nxt;

  always_comb begin
    p_sum = b_n2_r + b_ac_r;
    p_c   = p_sum & ~({MOD_W{1'b1}} << b_log2m_r);
    pp_c  = {p_c, {PHASE_BITS{1'b0}}} >> b_log2m_r;
    idx_c = pp_c[PHASE_BITS-1:0];

    rot_nxt.quad = cssg_quad_t'(idx_c[PHASE_BITS-1 -: 2]);
    rot_nxt.x    = CORDIC_X0;
    rot_nxt.y    = '0;
    rot_nxt.z    = {2'b00, idx_c[PHASE_BITS-3:0], {(ROT_W-PHASE_BITS){1'b0}}};
  end

  // Angle register, feeds the first rotation stage
  logic      rot_valid_r;
  cssg_rot_t rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_valid_r <= 1'b0;
    end else begin
      rot_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign rot_valid_o = rot_valid_r;
  assign rot_o       = rot_r;

endmodule

/* rtl/core/cssg_rot_stage.sv */
module cssg_rot_stage import cssg_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  cssg_rot_t rot_i,
  output logic      valid_o,
  output cssg_rot_t rot_o
);

  logic signed [ROT_W-1:0] x_c;
  logic signed [ROT_W-1:0] y_c;
  logic signed [ROT_W-1:0] z_c;
  logic signed [ROT_W-1:0] dx_c;
  logic signed [ROT_W-1:0] dy_c;
  cssg_rot_t               rot_nxt;

  // Rotate toward zero residual angle; shifts floor on negatives.
  always_comb begin
    x_c  = rot_i.x;
    y_c  = rot_i.y;
    z_c  = rot_i.z;
    dx_c = y_c >>> STAGE;
    dy_c = x_c >>> STAGE;
    rot_nxt.quad = rot_i.quad;
    if (!z_c[ROT_W-1]) begin
      rot_nxt.x = x_c - dx_c;
      rot_nxt.y = y_c + dy_c;
      rot_nxt.z = z_c - CORDIC_ATAN[STAGE];
    end else begin
      rot_nxt.x = x_c + dx_c;
      rot_nxt.y = y_c - dy_c;
      rot_nxt.z = z_c + CORDIC_ATAN[STAGE];
    end
  end

  logic      valid_r;
  cssg_rot_t rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign valid_o = valid_r;
  assign rot_o   = rot_r;

endmodule

/* rtl/core/cssg_out.sv */
module cssg_out import cssg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  cssg_rot_t               rot_i,
  output logic                    strobe_o,
  output logic signed [Q15_W-1:0] up_real_o,
  output logic signed [Q15_W-1:0] up_imag_o,
  output logic signed [Q15_W-1:0] down_real_o,
  output logic signed [Q15_W-1:0] down_imag_o
);

  localparam logic signed [ROT_W:0] RND = (ROT_W+1)'(Q15_HALF);

  // Round half up from Q30 and clip to Q15.
  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W:0] vx;
    logic signed [ROT_W:0] r;
    vx = {v[ROT_W-1], v};
    r  = (vx + RND) >>> Q15_FRAC;
    if (r > Q15_MAX) begin
      return Q15_MAX;
    end else if (r < Q15_MIN) begin
      return Q15_MIN;
    end
    return r[Q15_W-1:0];
  endfunction

  logic signed [ROT_W-1:0] x_c;
  logic signed [ROT_W-1:0] y_c;
  logic signed [ROT_W-1:0] xr_c;
  logic signed [ROT_W-1:0] yr_c;
  logic signed [Q15_W-1:0] cos_c;
  logic signed [Q15_W-1:0] sin_c;
  logic signed [Q15_W-1:0] dimag_c;

  always_comb begin
    x_c = rot_i.x;
    y_c = rot_i.y;
    case (rot_i.quad)
      QUAD_II: begin
        xr_c = -y_c;
        yr_c = x_c;
      end
      QUAD_III: begin
        xr_c = -x_c;
        yr_c = -y_c;
      end
      QUAD_IV: begin
        xr_c = y_c;
        yr_c = -x_c;
      end
      default: begin
        xr_c = x_c;
        yr_c = y_c;
      end
    endcase
    cos_c   = to_q15(xr_c);
    sin_c   = to_q15(yr_c);
    dimag_c = (sin_c == Q15_MIN) ? Q15_MAX : -sin_c;
  end

  logic                    strobe_r;
  logic signed [Q15_W-1:0] up_real_r;
  logic signed [Q15_W-1:0] up_imag_r;
  logic signed [Q15_W-1:0] down_imag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    up_real_r   <= cos_c;
    up_imag_r   <= sin_c;
    down_imag_r <= dimag_c;
  end

  assign strobe_o    = strobe_r;
  assign up_real_o   = up_real_r;
  assign up_imag_o   = up_imag_r;
  assign down_real_o = up_real_r;
  assign down_imag_o = down_imag_r;

endmodule

/* rtl/core/css_chirp_sample_generator_top.sv */
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+-------------------------------
// request  | start, busy, in_sample_index, in_symbol_value | start high while busy is low
// result   | out_strobe, out_up_real .. out_down_imag      | one strobe per result, no stall
// config   | cfg_wr_en, cfg_index, cfg_data                | any edge with cfg_wr_en high
//
// One request per clock; busy never rises. Each result passes through three
// phase registers (input, products, angle), one register per CORDIC
// micro-rotation (30), and the output register.
// Synchronous active-low reset clears the valid pipeline and sets the
// spreading factor to 7 and the oversampling exponent to 0.
// The receiver cannot stall, so results leave in request order, one per strobe.

`include "css_chirp_sample_generator_top_macros.svh"

module css_chirp_sample_generator_top import cssg_pkg::*; #(
  parameter int MAX_SF      = 12,
  parameter int MAX_OS_LOG2 = 3,
  parameter int PHASE_BITS  = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [SAMPLE_W-1:0]     in_sample_index,
  input  logic [SYMBOL_W-1:0]     in_symbol_value,
  // result channel
  output logic                    out_strobe,
  output logic signed [Q15_W-1:0] out_up_real,
  output logic signed [Q15_W-1:0] out_up_imag,
  output logic signed [Q15_W-1:0] out_down_real,
  output logic signed [Q15_W-1:0] out_down_imag,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers; the phase stage clamps them to legal range.
  logic [SF_W-1:0]  sf_r;
  logic [OSL_W-1:0] osl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r  <= SF_RESET;
      osl_r <= OSL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SPREADING_FACTOR: sf_r  <= cfg_data[SF_W-1:0];
        CFG_OVERSAMPLE_LOG2:  osl_r <= cfg_data[OSL_W-1:0];
        default: ;
      endcase
    end
  end

  // Fully pipelined: a request is taken every cycle.
  assign busy = 1'b0;

  logic      req;
  assign req = start && !busy;

  // Phase: wrap index and symbol, form the exact integer phase, scale to
  // PHASE_BITS and seed the rotation with quadrant and residual angle.
  logic      rot_vld  [CORDIC_STEPS+1];
  cssg_rot_t rot_pipe [CORDIC_STEPS+1];

  cssg_phase #(
    .MAX_SF      (MAX_SF),
    .MAX_OS_LOG2 (MAX_OS_LOG2),
    .PHASE_BITS  (PHASE_BITS)
  ) u_phase (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_i          (req),
    .sample_index_i (in_sample_index),
    .symbol_value_i (in_symbol_value),
    .sf_i           (sf_r),
    .osl_i          (osl_r),
    .rot_valid_o    (rot_vld[0]),
    .rot_o          (rot_pipe[0])
  );

  // One micro-rotation per stage; quadrant rides along untouched.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    cssg_rot_stage #(
      .STAGE (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (rot_vld[i]),
      .rot_i   (rot_pipe[i]),
      .valid_o (rot_vld[i+1]),
      .rot_o   (rot_pipe[i+1])
    );
  end

  // Quadrant fold, Q15 rounding and the conjugate, then the output register.
  cssg_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (rot_vld[CORDIC_STEPS]),
    .rot_i       (rot_pipe[CORDIC_STEPS]),
    .strobe_o    (out_strobe),
    .up_real_o   (out_up_real),
    .up_imag_o   (out_up_imag),
    .down_real_o (out_down_real),
    .down_imag_o (out_down_imag)
  );

  // Down-chirp imaginary part is the saturated negation of the up-chirp one.
  logic conj_ok;
  assign conj_ok = (out_up_imag != Q15_MIN && out_down_imag == -out_up_imag) ||
                   (out_up_imag == Q15_MIN && out_down_imag == Q15_MAX);

  // Every request comes out as a result strobe once through the pipeline.
  `CSSG_ASSERT_DLY(a_req_to_result, req, LATENCY, out_strobe, "request lost in pipeline")
  // No strobe without a matching request earlier in the pipeline.
  `CSSG_ASSERT_IMP(a_result_has_req, out_strobe, $past(req, LATENCY), "spurious result strobe")
  // Conjugate relation holds on every result.
  `CSSG_ASSERT_IMP(a_conj_imag, out_strobe, conj_ok, "conjugate mismatch")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb import cssg_pkg::*; ();

  // Build of the block under test
  localparam int SF_TOP   = 12;
  localparam int OSL_TOP  = 3;
  localparam int PH_BITS  = 12;

  // Run shape
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 125;
  localparam int STALL_LIMIT  = 500;
  localparam int PRINT_LIMIT  = 40;

  // Rotation constants: gain-compensated unit vector in Q30, and the
  // arctangent of 2^-i in 2^-32 turn units.
  localparam longint ROT_START = 64'sd652032874;
  localparam longint ARCTAN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  localparam logic signed [15:0] FULL_POS = 16'sh7fff;
  localparam logic signed [15:0] FULL_NEG = 16'sh8000;
  localparam logic signed [15:0] NEAR_NEG = 16'sh8001;
  localparam logic signed [15:0] ZERO_Q15 = 16'sh0000;

  typedef struct packed {
    logic signed [15:0] up_re;
    logic signed [15:0] up_im;
    logic signed [15:0] dn_re;
    logic signed [15:0] dn_im;
  } chirp_sample_t;

  typedef struct packed {
    logic [14:0]   idx;
    logic [11:0]   sym;
    chirp_sample_t smp;
  } chirp_pending_t;

  // One row of the hand-picked stimulus: the register values to run it
  // under, the request, and a typed-in sample where one can be read off
  // directly (exact quarter turns).
  typedef struct packed {
    logic [3:0]    sf;
    logic [1:0]    osl;
    logic [14:0]   idx;
    logic [11:0]   sym;
    logic          fixed;
    chirp_sample_t smp;
  } chirp_row_t;

  localparam chirp_sample_t NO_SAMPLE   = '0;
  localparam chirp_sample_t TURN_ZERO   = '{FULL_POS, ZERO_Q15, FULL_POS, ZERO_Q15};
  localparam chirp_sample_t TURN_QUART  = '{ZERO_Q15, FULL_POS, ZERO_Q15, NEAR_NEG};
  localparam chirp_sample_t TURN_HALF   = '{FULL_NEG, ZERO_Q15, FULL_NEG, ZERO_Q15};
  localparam chirp_sample_t TURN_3QUART = '{ZERO_Q15, FULL_NEG, ZERO_Q15, FULL_POS};

  localparam int DIRECTED_COUNT = 22;
  localparam chirp_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // reset setting: N = 128, no oversampling
    '{4'd7,  2'd0, 15'd0,     12'd0,    1'b1, TURN_ZERO},
    '{4'd7,  2'd0, 15'd8,     12'd64,   1'b1, TURN_QUART},
    '{4'd7,  2'd0, 15'd8,     12'd68,   1'b1, TURN_HALF},
    // sine at -1: the down-chirp imaginary part saturates
    '{4'd7,  2'd0, 15'd8,     12'd72,   1'b1, TURN_3QUART},
    // index and symbol wrap
    '{4'd7,  2'd0, 15'd32767, 12'd4095, 1'b0, NO_SAMPLE},
    // just before and right at the fold point
    '{4'd7,  2'd0, 15'd63,    12'd64,   1'b0, NO_SAMPLE},
    '{4'd7,  2'd0, 15'd64,    12'd64,   1'b0, NO_SAMPLE},
    '{4'd7,  2'd0, 15'd127,   12'd1,    1'b0, NO_SAMPLE},
    // smallest symbol, phase modulus narrower than the table
    '{4'd5,  2'd0, 15'd0,     12'd0,    1'b1, TURN_ZERO},
    '{4'd5,  2'd0, 15'd31,    12'd31,   1'b0, NO_SAMPLE},
    '{4'd5,  2'd0, 15'd17,    12'd4095, 1'b0, NO_SAMPLE},
    // spreading factor below range
    '{4'd0,  2'd0, 15'd5,     12'd1000, 1'b0, NO_SAMPLE},
    '{4'd4,  2'd1, 15'd60,    12'd3,    1'b0, NO_SAMPLE},
    // spreading factor above range
    '{4'd15, 2'd0, 15'd4095,  12'd4095, 1'b0, NO_SAMPLE},
    '{4'd15, 2'd1, 15'd32767, 12'd0,    1'b0, NO_SAMPLE},
    // largest symbol with the most oversampling, then mixed settings
    '{4'd12, 2'd3, 15'd0,     12'd4095, 1'b1, TURN_ZERO},
    '{4'd12, 2'd3, 15'd32767, 12'd4095, 1'b0, NO_SAMPLE},
    '{4'd12, 2'd3, 15'd16384, 12'd1,    1'b0, NO_SAMPLE},
    '{4'd12, 2'd3, 15'd8191,  12'd2048, 1'b0, NO_SAMPLE},
    '{4'd6,  2'd2, 15'd100,   12'd20,   1'b0, NO_SAMPLE},
    '{4'd11, 2'd3, 15'd21845, 12'd2730, 1'b0, NO_SAMPLE},
    '{4'd10, 2'd1, 15'd10922, 12'd1365, 1'b0, NO_SAMPLE}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [SAMPLE_W-1:0]     in_sample_index;
  logic [SYMBOL_W-1:0]     in_symbol_value;
  logic                    out_strobe;
  logic signed [Q15_W-1:0] out_up_real;
  logic signed [Q15_W-1:0] out_up_imag;
  logic signed [Q15_W-1:0] out_down_real;
  logic signed [Q15_W-1:0] out_down_imag;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Register copies as written, before any saturation
  logic [3:0] sf_reg;
  logic [1:0] osl_reg;

  chirp_pending_t chirp_pending_q [$];
  chirp_pending_t oldest_req;
  int unsigned    mismatch_count = 0;

  css_chirp_sample_generator_top #(
    .MAX_SF      (SF_TOP),
    .MAX_OS_LOG2 (OSL_TOP),
    .PHASE_BITS  (PH_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_index (in_sample_index),
    .in_symbol_value (in_symbol_value),
    .out_strobe      (out_strobe),
    .out_up_real     (out_up_real),
    .out_up_imag     (out_up_imag),
    .out_down_real   (out_down_real),
    .out_down_imag   (out_down_imag),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate the written spreading factor into the supported range.
  function automatic int unsigned clamp_sf(input logic [3:0] raw);
    if (raw < 4'd5) begin
      return 5;
    end
    if (raw > SF_TOP) begin
      return SF_TOP;
    end
    return raw;
  endfunction

  // Round a Q30 value to Q15 (half up, floor shift) and saturate.
  function automatic logic signed [15:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return 16'(r);
  endfunction

  // Work out the chirp sample for one request under the current registers:
  // exact integer phase, truncation to the table width, CORDIC, rounding.
  function automatic chirp_sample_t chirp_from_phase(input logic [14:0] sample_idx,
                                                     input logic [11:0] symbol);
    int unsigned     sf_eff;
    int unsigned     osl_eff;
    int unsigned     log2m;
    longint unsigned nbins;
    longint unsigned osf;
    longint unsigned n;
    longint unsigned id;
    longint unsigned nfold;
    longint unsigned ph;
    longint unsigned pidx;
    logic [31:0]     turn;
    cssg_quad_t      quad;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          xr;
    longint          yr;
    chirp_sample_t   res;

    sf_eff  = clamp_sf(sf_reg);
    osl_eff = (osl_reg > OSL_TOP) ? OSL_TOP : osl_reg;
    nbins   = 64'd1 << sf_eff;
    osf     = 64'd1 << osl_eff;
    n       = {49'd0, sample_idx} & ((nbins << osl_eff) - 64'd1);
    id      = {52'd0, symbol} & (nbins - 64'd1);
    nfold   = (nbins - id) * osf;

    ph = n * n + 64'd2 * id * n * osf - nbins * n * osf;
    if (n >= nfold) begin
      ph = ph - 64'd2 * nbins * n * osf;
    end
    log2m = 1 + sf_eff + 2 * osl_eff;
    ph    = ph & ((64'd1 << log2m) - 64'd1);

    // wide modulus: shift down; narrow modulus: shift up, nothing is cut off
    if (log2m >= PH_BITS) begin
      pidx = ph >> (log2m - PH_BITS);
    end else begin
      pidx = ph << (PH_BITS - log2m);
    end
    pidx = pidx & ((64'd1 << PH_BITS) - 64'd1);
    turn = 32'(pidx) << (32 - PH_BITS);

    quad = cssg_quad_t'(turn[31:30]);
    z    = {34'd0, turn[29:0]};
    x    = ROT_START;
    y    = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_STEP[i];
      end
    end

    case (quad)
      QUAD_II: begin
        xr = -y;
        yr = x;
      end
      QUAD_III: begin
        xr = -x;
        yr = -y;
      end
      QUAD_IV: begin
        xr = y;
        yr = -x;
      end
      default: begin
        xr = x;
        yr = y;
      end
    endcase

    res.up_re = round_q15(xr);
    res.up_im = round_q15(yr);
    res.dn_re = res.up_re;
    res.dn_im = (res.up_im == Q15_MIN) ? Q15_MAX : -res.up_im;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  // Drive one request and hold it until the block takes it. Record the
  // expected sample at the accepting edge; when gaps are allowed, drop
  // start at random afterwards, before the next request.
  task automatic send_request(input logic [14:0] idx, input logic [11:0] sym,
                              input bit gap_ok, input bit fixed,
                              input chirp_sample_t typed);
    chirp_pending_t entry;
    @(negedge clk);
    start           = 1'b1;
    in_sample_index = idx;
    in_symbol_value = sym;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    entry.idx = idx;
    entry.sym = sym;
    entry.smp = fixed ? typed : chirp_from_phase(idx, sym);
    chirp_pending_q.push_back(entry);
    if (gap_ok && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
  endtask

  // Stop issuing requests and let every pending sample come out before
  // the registers are touched.
  task automatic settle_idle();
    @(negedge clk);
    start = 1'b0;
    while (chirp_pending_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cssg_cfg_idx_t which, input logic [3:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = which;
    cfg_data  = data;
    @(posedge clk);
    if (which == CFG_SPREADING_FACTOR) begin
      sf_reg = data;
    end else begin
      osl_reg = data[1:0];
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Upper data bits of the oversampling write are don't-care: randomize
  // them so every cfg_data bit toggles.
  task automatic apply_setting(input logic [3:0] sf, input logic [1:0] osl,
                               input logic [1:0] junk);
    settle_idle();
    write_reg(CFG_SPREADING_FACTOR, sf);
    write_reg(CFG_OVERSAMPLE_LOG2, {junk, osl});
  endtask

  // Result checker: every strobe must match the oldest pending request,
  // field by field.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (chirp_pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result up=(%0d,%0d) down=(%0d,%0d)",
                                out_up_real, out_up_imag, out_down_real, out_down_imag));
      end else begin
        oldest_req = chirp_pending_q.pop_front();
        if (out_up_real !== oldest_req.smp.up_re) begin
          flag_mismatch($sformatf("up_real got %0d want %0d (idx %0d sym %0d sf %0d osl %0d)",
                                  out_up_real, oldest_req.smp.up_re, oldest_req.idx,
                                  oldest_req.sym, sf_reg, osl_reg));
        end
        if (out_up_imag !== oldest_req.smp.up_im) begin
          flag_mismatch($sformatf("up_imag got %0d want %0d (idx %0d sym %0d sf %0d osl %0d)",
                                  out_up_imag, oldest_req.smp.up_im, oldest_req.idx,
                                  oldest_req.sym, sf_reg, osl_reg));
        end
        if (out_down_real !== oldest_req.smp.dn_re) begin
          flag_mismatch($sformatf("down_real got %0d want %0d (idx %0d sym %0d sf %0d osl %0d)",
                                  out_down_real, oldest_req.smp.dn_re, oldest_req.idx,
                                  oldest_req.sym, sf_reg, osl_reg));
        end
        if (out_down_imag !== oldest_req.smp.dn_im) begin
          flag_mismatch($sformatf("down_imag got %0d want %0d (idx %0d sym %0d sf %0d osl %0d)",
                                  out_down_imag, oldest_req.smp.dn_im, oldest_req.idx,
                                  oldest_req.sym, sf_reg, osl_reg));
        end
      end
    end
  end

  // Watchdog: end the run once neither channel has moved for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned     span;
    int unsigned     nb;
    int unsigned     mode;
    int unsigned     n;
    int unsigned     id;
    int unsigned     nfold;
    logic [3:0]      sf_pick;
    logic [1:0]      osl_pick;
    logic [14:0]     idx;
    logic [11:0]     sym;
    bit              gap_ok;

    // Hold every input at a known value while reset is held.
    rst_n           = 1'b0;
    start           = 1'b0;
    in_sample_index = '0;
    in_symbol_value = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_SPREADING_FACTOR;
    cfg_data        = '0;
    sf_reg          = SF_RESET;
    osl_reg         = OSL_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: rewrite the registers whenever a row asks for a new
    // setting, then issue its request; rows under one setting go back to back.
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      if (DIRECTED_ROWS[r].sf != sf_reg || DIRECTED_ROWS[r].osl != osl_reg) begin
        apply_setting(DIRECTED_ROWS[r].sf, DIRECTED_ROWS[r].osl, 2'b00);
      end
      send_request(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].sym, 1'b0,
                   DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].smp);
    end

    // Random phases: extremes of both registers first, then random settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          sf_pick  = 4'd12;
          osl_pick = 2'd3;
        end
        1: begin
          sf_pick  = 4'd5;
          osl_pick = 2'd0;
        end
        2: begin
          sf_pick  = 4'd15;
          osl_pick = 2'd3;
        end
        3: begin
          sf_pick  = 4'd0;
          osl_pick = 2'd2;
        end
        default: begin
          sf_pick  = 4'($urandom_range(0, 15));
          osl_pick = 2'($urandom_range(0, 3));
        end
      endcase
      apply_setting(sf_pick, osl_pick, 2'($urandom_range(0, 3)));

      nb   = 1 << clamp_sf(sf_reg);
      span = nb << osl_reg;
      // Random gaps in most phases; every third phase and the closing ones run
      // back to back.
      gap_ok = (phase < PHASES - 2) && (phase % 3 != 2);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        mode = $urandom_range(0, 9);
        if (mode <= 4) begin
          // anything the fields allow, wrapping included
          idx = 15'($urandom);
          sym = 12'($urandom);
        end else if (mode <= 7) begin
          // within one symbol
          idx = 15'($urandom % span);
          sym = 12'($urandom % nb);
        end else if (mode == 8) begin
          // straddle the fold point
          id    = $urandom % nb;
          nfold = (nb - id) << osl_reg;
          n     = nfold - 1 + $urandom_range(0, 2);
          if (n >= span) begin
            n = span - 1;
          end
          idx = 15'(n);
          sym = 12'(id);
        end else begin
          // corners of index and symbol
          case ($urandom_range(0, 2))
            0: idx = 15'd0;
            1: idx = 15'(span - 1);
            default: idx = 15'h7fff;
          endcase
          case ($urandom_range(0, 2))
            0: sym = 12'd0;
            1: sym = 12'(nb - 1);
            default: sym = 12'hfff;
          endcase
        end
        send_request(idx, sym, gap_ok, 1'b0, NO_SAMPLE);
      end
    end

    // Drain, then watch a full pipeline length for stray results.
    settle_idle();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
